/* rtl/bcp_pkg.sv */
// ----------------------------------------------------------------------------
// Battery charge policy package
// Shared types, codes and reset constants for the charge policy unit.
// ----------------------------------------------------------------------------
package bcp_pkg;

    localparam int ADC_BITS_DEF = 10;
    localparam int TICK_BITS    = 6;
    localparam int CFG_IDX_BITS = 3;

    // Register reset values
    localparam int PRESENCE_LEVEL_RST   = 100;
    localparam int OFF_LEVEL_RST        = 600;
    localparam int LOW_LEVEL_RST        = 700;
    localparam int GRACE_START_RST      = 2;
    localparam int GRACE_END_RST        = 20;
    localparam int GRACE_DONE_LEVEL_RST = 10;

    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_USB      = 2'd1,
        OP_BATT_IRQ = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        USB_NONE = 2'd0,
        USB_UFP  = 2'd1,
        USB_PD   = 2'd2
    } usb_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_PRESENCE_LEVEL   = 3'd0,
        REG_OFF_LEVEL        = 3'd1,
        REG_LOW_LEVEL        = 3'd2,
        REG_GRACE_START      = 3'd3,
        REG_GRACE_END        = 3'd4,
        REG_GRACE_DONE_LEVEL = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic                 battery_present;
        logic                 poe_seen;
        logic                 battery_flat;
        logic                 battery_weak;
        logic [1:0]           usb_mode;
        logic                 presence_debounce;
        logic [TICK_BITS-1:0] grace_ticks;
        logic                 grace_over;
        logic                 charge_enable_held;
        logic                 high_current_held;
        logic                 led_held;
    } bcp_state_t;

    typedef struct packed {
        logic charge_enable;
        logic high_current;
        logic led_on;
        logic power_off_request;
        logic recomputed;
    } bcp_result_t;

endpackage

/* rtl/bcp_core.sv */
// ----------------------------------------------------------------------------
// Battery charge policy core
// Next-state and drive-level evaluation for one event.
// ----------------------------------------------------------------------------
module bcp_core
    import bcp_pkg::*;
#(
    parameter int ADC_BITS = ADC_BITS_DEF
)
(
    input  bcp_state_t           state,
    input  logic [1:0]           operation,
    input  logic [ADC_BITS-1:0]  adc_sample,
    input  logic                 adc_error,
    input  logic                 poe_present,
    input  logic [1:0]           usb_state,
    input  logic [ADC_BITS-1:0]  presence_level,
    input  logic [ADC_BITS-1:0]  off_level,
    input  logic [ADC_BITS-1:0]  low_level,
    input  logic [TICK_BITS-1:0] grace_start,
    input  logic [TICK_BITS-1:0] grace_end,
    input  logic [TICK_BITS-1:0] grace_done_level,
    output bcp_state_t           state_next,
    output bcp_result_t          result
);

    logic                 present;
    logic                 flat;
    logic                 low_batt;
    logic                 changed;
    logic                 chg;
    logic                 hi;
    logic                 led;
    logic                 off;
    logic [1:0]           usb_norm;
    logic [TICK_BITS-1:0] ticks_inc;
    bcp_state_t           st;

    assign ticks_inc = state.grace_ticks + 1'b1;
    assign usb_norm  = (usb_state == 2'd3) ? USB_PD : usb_state;

    always_comb
    begin
        st       = state;
        present  = 1'b0;
        flat     = 1'b0;
        low_batt = 1'b0;
        changed  = 1'b0;

        case (operation)
            OP_TICK:
            begin
                if (adc_error)
                begin
                    present = 1'b0;
                end
                else if (adc_sample > presence_level)
                begin
                    if (!state.battery_present)
                    begin
                        // two samples in a row above the level
                        if (state.presence_debounce)
                        begin
                            present              = 1'b1;
                            st.presence_debounce = 1'b0;
                        end
                        else
                        begin
                            st.presence_debounce = 1'b1;
                        end
                    end
                    else
                    begin
                        present = 1'b1;
                    end
                    if (adc_sample < off_level)
                        flat = 1'b1;
                    else if (adc_sample < low_level)
                        low_batt = 1'b1;
                end
                else
                begin
                    st.presence_debounce = 1'b0;
                end

                if (!state.grace_over)
                begin
                    st.grace_ticks = ticks_inc;
                    if (ticks_inc < grace_end && ticks_inc > grace_start)
                        present = 1'b1;
                    else if (ticks_inc >= grace_done_level)
                        st.grace_over = 1'b1;
                end

                if (present != state.battery_present || poe_present != state.poe_seen ||
                    flat != state.battery_flat || low_batt != state.battery_weak)
                begin
                    st.battery_present = present;
                    st.poe_seen        = poe_present;
                    st.battery_flat    = flat;
                    st.battery_weak    = low_batt;
                    changed            = 1'b1;
                end
            end
            OP_USB:
            begin
                if (usb_norm != state.usb_mode)
                begin
                    st.usb_mode = usb_norm;
                    changed     = 1'b1;
                end
            end
            OP_BATT_IRQ:
            begin
                if (!state.battery_present)
                begin
                    st.battery_present = 1'b1;
                    changed            = 1'b1;
                end
            end
            default:
            begin
                st = state;
            end
        endcase
    end

    // Drive levels from the updated flags
    always_comb
    begin
        chg = 1'b0;
        hi  = 1'b0;
        led = 1'b0;
        off = 1'b0;
        if (st.battery_present)
        begin
            if (st.poe_seen)
            begin
                chg = 1'b1;
                hi  = 1'b1;
            end
            else if (st.usb_mode != USB_NONE)
            begin
                chg = !(st.usb_mode == USB_UFP && !st.grace_over);
                hi  = (st.usb_mode == USB_PD);
            end
            else if (st.battery_weak)
            begin
                led = 1'b1;
            end
            else if (st.battery_flat)
            begin
                off = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next = st;
        if (changed)
        begin
            state_next.charge_enable_held = chg;
            state_next.high_current_held  = chg && hi;
            state_next.led_held           = led;
        end
        result.charge_enable     = state_next.charge_enable_held;
        result.high_current      = state_next.high_current_held;
        result.led_on            = state_next.led_held;
        result.power_off_request = changed && off;
        result.recomputed        = changed;
    end

endmodule

/* rtl/battery_charge_policy_unit.sv */
// Path: an accepted beat goes to the input register, its result beat to the
// result register. Throughput: one event per cycle while not stalled; the
// input register takes a beat while a result waits stalled, if it is empty.
// Reset: asynchronous, active low; clears the policy state and the valid
// flags and loads the threshold registers with their default levels.
// ----------------------------------------------------------------------------
// Battery charge policy unit
// Tracks battery presence, level and charge source; drives charger controls.
// ----------------------------------------------------------------------------
module battery_charge_policy_unit
    import bcp_pkg::*;
#(
    parameter int ADC_BITS = ADC_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    // configuration
    input  logic                    cfg_write,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [ADC_BITS-1:0]     cfg_data,
    // event channel
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [1:0]              operation,
    input  logic [ADC_BITS-1:0]     adc_sample,
    input  logic                    adc_error,
    input  logic                    poe_present,
    input  logic [1:0]              usb_state,
    // result channel
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic                    charge_enable,
    output logic                    high_current,
    output logic                    led_on,
    output logic                    power_off_request,
    output logic                    recomputed
);

    logic [ADC_BITS-1:0]  presence_level_reg;
    logic [ADC_BITS-1:0]  off_level_reg;
    logic [ADC_BITS-1:0]  low_level_reg;
    logic [TICK_BITS-1:0] grace_start_reg;
    logic [TICK_BITS-1:0] grace_end_reg;
    logic [TICK_BITS-1:0] grace_done_level_reg;

    logic                 s1_valid_reg;
    logic [1:0]           op_reg;
    logic [ADC_BITS-1:0]  adc_reg;
    logic                 err_reg;
    logic                 poe_reg;
    logic [1:0]           usb_reg;

    logic                 out_valid_reg;
    bcp_result_t          res_reg;
    bcp_result_t          res_next;

    bcp_state_t           state_reg;
    bcp_state_t           state_next;

    logic                 s2_load;
    logic                 s1_fire;
    logic                 in_accept;

    assign s2_load   = !out_valid_reg || !out_stall;
    assign s1_fire   = s1_valid_reg && s2_load;
    assign in_stall  = s1_valid_reg && !s2_load;
    assign in_accept = in_valid && !in_stall;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            presence_level_reg   <= ADC_BITS'(PRESENCE_LEVEL_RST);
            off_level_reg        <= ADC_BITS'(OFF_LEVEL_RST);
            low_level_reg        <= ADC_BITS'(LOW_LEVEL_RST);
            grace_start_reg      <= TICK_BITS'(GRACE_START_RST);
            grace_end_reg        <= TICK_BITS'(GRACE_END_RST);
            grace_done_level_reg <= TICK_BITS'(GRACE_DONE_LEVEL_RST);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_PRESENCE_LEVEL:   presence_level_reg   <= cfg_data;
                REG_OFF_LEVEL:        off_level_reg        <= cfg_data;
                REG_LOW_LEVEL:        low_level_reg        <= cfg_data;
                REG_GRACE_START:      grace_start_reg      <= cfg_data[TICK_BITS-1:0];
                REG_GRACE_END:        grace_end_reg        <= cfg_data[TICK_BITS-1:0];
                REG_GRACE_DONE_LEVEL: grace_done_level_reg <= cfg_data[TICK_BITS-1:0];
                default:              ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_accept)
            s1_valid_reg <= 1'b1;
        else if (s1_fire)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg  <= operation;
            adc_reg <= adc_sample;
            err_reg <= adc_error;
            poe_reg <= poe_present;
            usb_reg <= usb_state;
        end
    end

    bcp_core #(
        .ADC_BITS (ADC_BITS)
    ) u_core (
        .state            (state_reg),
        .operation        (op_reg),
        .adc_sample       (adc_reg),
        .adc_error        (err_reg),
        .poe_present      (poe_reg),
        .usb_state        (usb_reg),
        .presence_level   (presence_level_reg),
        .off_level        (off_level_reg),
        .low_level        (low_level_reg),
        .grace_start      (grace_start_reg),
        .grace_end        (grace_end_reg),
        .grace_done_level (grace_done_level_reg),
        .state_next       (state_next),
        .result           (res_next)
    );

    // Policy state advances as a beat moves into the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (s1_fire)
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_fire)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
            res_reg <= res_next;
    end

    assign out_valid         = out_valid_reg;
    assign charge_enable     = res_reg.charge_enable;
    assign high_current      = res_reg.high_current;
    assign led_on            = res_reg.led_on;
    assign power_off_request = res_reg.power_off_request;
    assign recomputed        = res_reg.recomputed;

endmodule

/* rtl/bcp_checker.sv */
// ----------------------------------------------------------------------------
// Battery charge policy checker
// Port-level checks on result beats of the charge policy unit.
// ----------------------------------------------------------------------------
module bcp_checker
(
    input logic clk,
    input logic rst_n,
    input logic out_valid,
    input logic out_stall,
    input logic charge_enable,
    input logic high_current,
    input logic led_on,
    input logic power_off_request,
    input logic recomputed
);

    // Power-off only comes out of a fresh evaluation
    ast_off_needs_recompute: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && power_off_request) |-> recomputed
    ) else $error("power-off request on a beat that was not recomputed");

    // Power-off means no charging and no low-battery LED
    ast_off_exclusive: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && power_off_request) |-> (!charge_enable && !led_on)
    ) else $error("power-off request together with charge or LED drive");

    // High current only while charging
    ast_high_needs_charge: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && high_current) |-> charge_enable
    ) else $error("high current selected without charge enable");

    // Stalled beat stays presented
    ast_valid_holds: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid
    ) else $error("result beat dropped while stalled");

endmodule

bind battery_charge_policy_unit bcp_checker u_bcp_checker (.*);
